@@ rtl/core/mmeg_pkg.sv @@
// package: shared types and constants of the multimode envelope generator
package mmeg_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VOICE_W = 3;
  localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int LEVEL_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int MODE_W = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = '1;

  typedef enum logic [1:0] {
    PH_NONE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  localparam logic [MODE_W-1:0] MODE_AD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AR    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARPT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADRPT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOP  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_SLOPE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SLOPE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENV_MODE      = 2'd2;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] attack_slope;
    logic [LEVEL_W-1:0] release_slope;
    logic [MODE_W-1:0]  env_mode;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_t             phase;
  } entry_t;

endpackage

@@ rtl/core/mmeg_update.sv @@
// module: next level and phase of one voice for one event
module mmeg_update (
  input  logic [1:0]      op,
  input  mmeg_pkg::cfg_t   cfg,
  input  mmeg_pkg::entry_t cur,
  output mmeg_pkg::entry_t nxt,
  output logic            fin
);
  import mmeg_pkg::*;

  logic [LEVEL_W:0] att_sum;
  logic             att_top;
  logic             rel_end;
  logic             mode_rel_ok;

  assign att_sum = {1'b0, cur.level} + {1'b0, cfg.attack_slope};
  assign att_top = att_sum >= {1'b0, FULL_LEVEL};
  assign rel_end = cur.level <= cfg.release_slope;
  assign mode_rel_ok = (cfg.env_mode == MODE_AD) || (cfg.env_mode == MODE_AR) ||
                       (cfg.env_mode == MODE_ARPT);

  always_comb begin
    nxt = cur;
    fin = 1'b0;
    case (opcode_t'(op))
      OP_TICK: begin
        if (cur.phase == PH_ATTACK) begin
          if (att_top) begin
            nxt.level = FULL_LEVEL;
            if ((cfg.env_mode == MODE_AD) || (cfg.env_mode == MODE_ADRPT) ||
                (cfg.env_mode == MODE_LOOP)) begin
              nxt.phase = PH_RELEASE;
            end else if (cfg.env_mode == MODE_ARPT) begin
              nxt.level = '0;
              nxt.phase = PH_ATTACK;
            end else begin
              nxt.phase = PH_SUSTAIN;
            end
          end else begin
            nxt.level = att_sum[LEVEL_W-1:0];
          end
        end else if (cur.phase == PH_RELEASE) begin
          if (rel_end) begin
            nxt.level = '0;
            if ((cfg.env_mode == MODE_LOOP) || (cfg.env_mode == MODE_ADRPT)) begin
              nxt.phase = PH_ATTACK;
            end else begin
              nxt.phase = PH_NONE;
              fin = 1'b1;
            end
          end else begin
            nxt.level = cur.level - cfg.release_slope;
          end
        end
      end
      OP_TRIGGER: begin
        nxt.phase = PH_ATTACK;
        nxt.level = (cfg.attack_slope == FULL_LEVEL) ? FULL_LEVEL : '0;
      end
      OP_RELEASE: begin
        if (mode_rel_ok) begin
          if ((cur.phase == PH_ATTACK) || (cur.phase == PH_SUSTAIN)) begin
            nxt.phase = PH_RELEASE;
            if (cfg.release_slope == FULL_LEVEL) begin
              nxt.level = '0;
            end
          end
        end else if (cfg.env_mode == MODE_ADRPT) begin
          nxt.level = '0;
          nxt.phase = PH_NONE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

@@ rtl/core/multimode_envelope_generator_core.sv @@
// module: top level of the multimode envelope generator bank
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------
//  in      | in_valid/in_ready  | opcode, voice
//  out     | out_valid/out_ready| out_voice, level, phase, finished
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// each transaction is a state memory read, then update and write back
// one transaction in flight at a time, so the voice memory is never read and written together
// rst loads config defaults (full-level slopes, AR mode), clears control state and per-voice valid bits
// a waiting result holds the update stage; input is taken again once it is written
module multimode_envelope_generator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic [mmeg_pkg::VOICE_W-1:0]          voice,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mmeg_pkg::VOICE_W-1:0]          out_voice,
  output logic [mmeg_pkg::LEVEL_W-1:0]          level,
  output logic [1:0]                            phase,
  output logic                                  finished,
  input  logic                                  cfg_we,
  input  logic [mmeg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mmeg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mmeg_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;

  entry_t mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] ent_valid;

  entry_t             rd_data;
  logic               rd_valid;
  logic [1:0]         op_q;
  logic [VOICE_W-1:0] voice_q;
  logic               in_range_q;

  entry_t cur;
  entry_t nxt;
  logic   fin;
  logic   in_acc;
  logic   upd_fire;
  logic   in_range;

  assign in_range = {1'b0, voice} < (VOICE_W + 1)'(NUM_VOICES);
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_slope  <= FULL_LEVEL;
      cfg.release_slope <= FULL_LEVEL;
      cfg.env_mode      <= MODE_AR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_SLOPE:  cfg.attack_slope  <= cfg_data;
        REG_RELEASE_SLOPE: cfg.release_slope <= cfg_data;
        REG_ENV_MODE:      cfg.env_mode      <= cfg_data[MODE_W-1:0];
        default:           cfg.env_mode      <= cfg.env_mode;
      endcase
    end
  end

  // state memory: read at accept, write back at update
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= mem[voice[IDX_W-1:0]];
      op_q    <= opcode;
      voice_q <= voice;
    end
    if (upd_fire && in_range_q) begin
      mem[voice_q[IDX_W-1:0]] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid  <= '0;
      rd_valid   <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_valid   <= ent_valid[voice[IDX_W-1:0]] && in_range;
        in_range_q <= in_range;
      end
      if (upd_fire && in_range_q) begin
        ent_valid[voice_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_comb begin
    cur = rd_valid ? rd_data : '{level: '0, phase: PH_NONE};
  end

  mmeg_update u_update (
    .op  (op_q),
    .cfg (cfg),
    .cur (cur),
    .nxt (nxt),
    .fin (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    upd_fire   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (!out_valid || out_ready) begin
          upd_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_voice <= voice_q;
      level     <= in_range_q ? nxt.level : '0;
      phase     <= in_range_q ? nxt.phase : PH_NONE;
      finished  <= in_range_q && fin;
    end
  end

endmodule
